### rtl/rdc_pkg.sv
// Shared types, constants and helpers for the radix digit converter.
package rdc_pkg;

  localparam int unsigned DigitW  = 6;
  localparam int unsigned CharW   = 7;
  localparam int unsigned RadixW  = 6;

  localparam logic [RadixW-1:0] RadixMin    = 6'd2;
  localparam logic [RadixW-1:0] RadixMax    = 6'd36;
  localparam logic [DigitW-1:0] DecimalSpan = 6'd10;
  localparam logic [CharW-1:0]  CharZero    = 7'd48;
  localparam logic [CharW-1:0]  CharA       = 7'd65;

  typedef struct packed {
    logic en;
    logic carry;
  } rdc_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SKIP,
    ST_EMIT
  } rdc_state_e;

  function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] res;
    if (d < DecimalSpan) begin
      res = CharZero + CharW'(d);
    end else begin
      res = CharA + CharW'(d - DecimalSpan);
    end
    return res;
  endfunction

endpackage

### rtl/radix_digit_converter_core.sv
// Binary to base-N ASCII converter: a chain of digit cells and its sequencer.
// Sequence: the value is fed MSB first into the cell chain while the carry wave
// ripples up, leading zeros are then stepped past, and each digit is then emitted.
// A new value is accepted only while idle, so not until the last digit of the
// previous value has been emitted; output stalls hold the digit shift-out.
// Reset: asynchronous, active low; radix returns to 2, the block idles empty.
module radix_digit_converter_core #(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned MAX_DIGITS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rdc_pkg::RadixW-1:0] cfg_radix_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [VALUE_BITS-1:0]      value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rdc_pkg::CharW-1:0]  digit_char_o,
  output logic                       last_digit_o
);
  import rdc_pkg::*;

  localparam int unsigned StepW = $clog2(VALUE_BITS + MAX_DIGITS);
  localparam int unsigned RemW  = $clog2(MAX_DIGITS + 1);
  localparam logic [StepW-1:0] StepLast = StepW'(VALUE_BITS + MAX_DIGITS - 2);
  localparam logic [StepW-1:0] StepFeed = StepW'(VALUE_BITS);
  localparam logic [RemW-1:0]  RemFull  = RemW'(MAX_DIGITS);
  localparam logic [RemW-1:0]  RemOne   = RemW'(1);

  rdc_state_e state_q, state_d;
  logic [RadixW-1:0]     radix_q, radix_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic                  out_valid_q, out_valid_d;
  logic [CharW-1:0]      char_q, char_d;
  logic                  last_q, last_d;
  logic                  ovf_q, ovf_d;

  logic      in_fire, clear, shift, out_free, top_carry;
  rdc_link_t link [MAX_DIGITS+1];
  logic [DigitW-1:0] cell_digit [MAX_DIGITS];
  logic [DigitW-1:0] top_digit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign top_digit   = cell_digit[MAX_DIGITS-1];
  assign clear       = in_fire;
  // carry out of the top cell: value needs more digits than the chain holds
  assign top_carry   = link[MAX_DIGITS].en && link[MAX_DIGITS].carry;

  assign link[0].en    = (state_q == ST_ACCUM) && (step_q < StepFeed);
  assign link[0].carry = value_q[VALUE_BITS-1];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [DigitW-1:0] shift_src;
    if (i == 0) begin : g_first
      assign shift_src = '0;
    end else begin : g_rest
      assign shift_src = cell_digit[i-1];
    end
    rdc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear),
      .shift_i    (shift),
      .radix_i    (radix_q),
      .link_i     (link[i]),
      .shift_in_i (shift_src),
      .digit_o    (cell_digit[i]),
      .link_o     (link[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    value_d     = value_q;
    step_d      = step_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    ovf_d       = ovf_q || top_carry;
    shift       = 1'b0;

    if (cfg_valid_i) radix_d = clamp_radix(cfg_radix_i);
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          value_d = value_i;
          step_d  = '0;
          ovf_d   = 1'b0;
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        value_d = {value_q[VALUE_BITS-2:0], 1'b0};
        step_d  = step_q + StepW'(1);
        if (step_q == StepLast) begin
          rem_d   = RemFull;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && rem_q != RemOne && !ovf_q && !top_carry) begin
          shift = 1'b1;
          rem_d = rem_q - RemW'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_to_ascii(top_digit);
          last_d      = (rem_q == RemOne);
          shift       = 1'b1;
          rem_d       = rem_q - RemW'(1);
          if (rem_q == RemOne) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RadixMin;
      step_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      step_q      <= step_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_ACCUM) && (step_q == '0))
    else $error("accepted transaction did not start accumulation");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("digit counter empty while emitting");

  a_wave_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP && $past(state_q) == ST_SKIP) |-> !link[MAX_DIGITS].en)
    else $error("carry wave still moving after accumulation");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                     (digit_char_o >= 7'd65 && digit_char_o <= 7'd90)))
    else $error("digit character out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && rem_q == RemOne) |=>
      (state_q == ST_IDLE && last_digit_o && out_valid_o))
    else $error("final digit did not end the transaction");
`endif

endmodule

### rtl/rdc_cell.sv
// One digit cell: clears, shifts, or doubles its digit plus incoming carry modulo the radix.
module rdc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       shift_i,
  input  logic [rdc_pkg::RadixW-1:0] radix_i,
  input  rdc_pkg::rdc_link_t         link_i,
  input  logic [rdc_pkg::DigitW-1:0] shift_in_i,
  output logic [rdc_pkg::DigitW-1:0] digit_o,
  output rdc_pkg::rdc_link_t         link_o
);
  import rdc_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;
  rdc_link_t         link_q, link_d;
  logic [DigitW:0]   dbl;
  logic              wrap;

  assign dbl  = {digit_q, link_i.carry};
  assign wrap = dbl >= {1'b0, radix_i};

  always_comb begin
    digit_d = digit_q;
    link_d  = '0;
    if (clear_i) begin
      digit_d = '0;
    end else if (shift_i) begin
      digit_d = shift_in_i;
    end else if (link_i.en) begin
      digit_d      = wrap ? DigitW'(dbl - {1'b0, radix_i}) : DigitW'(dbl);
      link_d.en    = 1'b1;
      link_d.carry = wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      link_q  <= '0;
    end else begin
      digit_q <= digit_d;
      link_q  <= link_d;
    end
  end

  assign digit_o = digit_q;
  assign link_o  = link_q;

endmodule
